/* design/arpc_pkg.sv */
// arpc_pkg: shared types, codes and widths for the arp cache table
// used by arpc_ctrl, arpc_dp and arp_cache_table_top
// no dependencies
package arpc_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - MAC_W - STATUS_W;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ADD    = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_DONE = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    RES_FULL = 2'd0,
    RES_HIT  = 2'd1,
    RES_MISS = 2'd2
  } res_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
    res_t res;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic add;
    logic full;
    logic match;
    logic exhausted;
    logic out_free;
  } stat_t;

endpackage

/* design/arpc_ram.sv */
// arpc_ram: generic single write port, single read port ram with registered read
// no dependencies
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/arpc_ctrl.sv */
// arpc_ctrl: controller state machine for the arp cache table
// depends on arpc_pkg
module arpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  arpc_pkg::stat_t stat,
  output arpc_pkg::cmd_t  cmd
);

  arpc_pkg::state_t state_r;
  arpc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpc_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.scan     = 1'b0;
    cmd.finish   = 1'b0;
    cmd.res      = arpc_pkg::RES_MISS;
    cmd.out_load = 1'b0;
    case (state_r)
      arpc_pkg::FSM_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = arpc_pkg::FSM_SCAN;
        end
      end
      arpc_pkg::FSM_SCAN: begin
        if (stat.add && stat.full) begin
          cmd.finish = 1'b1;
          cmd.res    = arpc_pkg::RES_FULL;
          state_nxt  = arpc_pkg::FSM_DONE;
        end else if (stat.match) begin
          cmd.finish = 1'b1;
          cmd.res    = arpc_pkg::RES_HIT;
          state_nxt  = arpc_pkg::FSM_DONE;
        end else if (stat.exhausted) begin
          cmd.finish = 1'b1;
          cmd.res    = arpc_pkg::RES_MISS;
          state_nxt  = arpc_pkg::FSM_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      arpc_pkg::FSM_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = arpc_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = arpc_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

/* design/arpc_dp.sv */
// arpc_dp: datapath of the arp cache table (entry ram, count, scan index, result)
// depends on arpc_pkg and arpc_ram
module arpc_dp #(
  parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [arpc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [arpc_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  arpc_pkg::cmd_t                   cmd,
  output arpc_pkg::stat_t                  stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [arpc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = arpc_pkg::IP_W + arpc_pkg::MAC_W;

  arpc_pkg::op_t               op_r, op_nxt;
  logic [arpc_pkg::IP_W-1:0]   ip_r, ip_nxt;
  logic [arpc_pkg::MAC_W-1:0]  mac_r, mac_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic                        hit_r, hit_nxt;
  logic [arpc_pkg::MAC_W-1:0]  macf_r, macf_nxt;
  arpc_pkg::status_t           status_r, status_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic [arpc_pkg::MAC_W-1:0]  out_mac_r, out_mac_nxt;
  arpc_pkg::status_t           out_status_r, out_status_nxt;

  logic                        wr_en;
  logic                        rd_en;
  logic [ENT_W-1:0]            rd_data;
  logic [arpc_pkg::IP_W-1:0]   rd_ip;
  logic [arpc_pkg::MAC_W-1:0]  rd_mac;
  logic                        is_lookup;

  arpc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({mac_r, ip_r}),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_ip     = rd_data[arpc_pkg::IP_W-1:0];
  assign rd_mac    = rd_data[ENT_W-1:arpc_pkg::IP_W];
  assign is_lookup = (op_r == arpc_pkg::OP_LOOKUP);

  assign stat.add       = (op_r == arpc_pkg::OP_ADD);
  assign stat.full      = (count_r == CNT_W'(TABLE_DEPTH));
  assign stat.match     = cmp_vld_r && (rd_ip == ip_r);
  assign stat.exhausted = (idx_r == count_r) && !cmp_vld_r;
  assign stat.out_free  = !out_vld_r || out_tready;

  assign rd_en = cmd.scan && (idx_r != count_r);
  assign wr_en = cmd.finish && (cmd.res == arpc_pkg::RES_MISS) && !is_lookup;

  always_comb begin
    op_nxt         = op_r;
    ip_nxt         = ip_r;
    mac_nxt        = mac_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    hit_nxt        = hit_r;
    macf_nxt       = macf_r;
    status_nxt     = status_r;
    out_vld_nxt    = out_vld_r;
    out_hit_nxt    = out_hit_r;
    out_mac_nxt    = out_mac_r;
    out_status_nxt = out_status_r;

    if (cmd.load) begin
      op_nxt      = arpc_pkg::op_t'(in_tuser[0]);
      ip_nxt      = in_tdata[arpc_pkg::IP_W-1:0];
      mac_nxt     = in_tdata[ENT_W-1:arpc_pkg::IP_W];
      idx_nxt     = '0;
      cmp_vld_nxt = 1'b0;
    end

    if (cmd.scan) begin
      cmp_vld_nxt = rd_en;
      if (rd_en) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end

    if (cmd.finish) begin
      cmp_vld_nxt = 1'b0;
      hit_nxt     = 1'b0;
      macf_nxt    = '0;
      case (cmd.res)
        arpc_pkg::RES_FULL: begin
          status_nxt = arpc_pkg::ST_FULL;
        end
        arpc_pkg::RES_HIT: begin
          hit_nxt = 1'b1;
          if (is_lookup) begin
            macf_nxt   = rd_mac;
            status_nxt = arpc_pkg::ST_OK;
          end else begin
            status_nxt = arpc_pkg::ST_DUPLICATE;
          end
        end
        arpc_pkg::RES_MISS: begin
          if (is_lookup) begin
            status_nxt = arpc_pkg::ST_NOT_FOUND;
          end else begin
            status_nxt = arpc_pkg::ST_OK;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        default: begin
          status_nxt = arpc_pkg::ST_NOT_FOUND;
        end
      endcase
    end

    if (cmd.out_load) begin
      out_vld_nxt    = 1'b1;
      out_hit_nxt    = hit_r;
      out_mac_nxt    = macf_r;
      out_status_nxt = status_r;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ip_r         <= ip_nxt;
    mac_r        <= mac_nxt;
    hit_r        <= hit_nxt;
    macf_r       <= macf_nxt;
    status_r     <= status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_mac_r    <= out_mac_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{arpc_pkg::OUT_PAD_W{1'b0}}, out_status_r, out_mac_r, out_hit_r};

endmodule

/* design/arp_cache_table_top.sv */
// arp_cache_table_top: arp cache table, ipv4 address to mac lookup and insert
// depends on arpc_pkg, arpc_ctrl, arpc_dp (and arpc_ram below it)
//
// usage:
//   input channel (in_*): in_tuser carries the opcode (0 lookup, 1 add),
//   in_tdata the ip address and the mac address to insert.
//   output channel (out_*): exactly one result transfer per input transfer,
//   out_tdata carries hit, mac_found and status.
//   one item is worked on at a time; in_tready is high only while idle.
//   the entries are scanned oldest first through the entry ram read port,
//   one entry per cycle, stopping at the first match; a miss reads every
//   entry, and an add to a full table or any item on an empty table reads
//   none. with a ready receiver the next item is taken at the same edge as
//   the result transfer. the result sits in an output register; the next
//   item is taken while it waits, and a stalled receiver holds the block
//   only once a second result is ready. reset clears the entry count and
//   both valid flags; the ram contents are not cleared, since only written
//   entries are read.
module arp_cache_table_top #(
  parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [arpc_pkg::IN_TDATA_W-1:0]  in_tdata,   // ip_address[31:0], mac_address[79:32]
  input  logic [arpc_pkg::IN_TUSER_W-1:0]  in_tuser,   // opcode[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [arpc_pkg::OUT_TDATA_W-1:0] out_tdata   // hit[0], mac_found[48:1], status[50:49]
);

  arpc_pkg::cmd_t  cmd;
  arpc_pkg::stat_t stat;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  arpc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
